// ===== rtl/core/toroidal_life_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the toroidal life engine
// Each macro is a labelled concurrent assertion that is disabled by reset.
// Defining NO_ASSERTIONS removes them all.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_ENGINE_ASSERT_SVH
`define TOROIDAL_LIFE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TLE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("toroidal_life_engine: assertion failed");

// next-cycle implication
`define TLE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("toroidal_life_engine: assertion failed");

`else

`define TLE_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLE_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// Toroidal life engine package
// Request and response types, grid defaults, xorshift and colour helpers.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int unsigned GRID_WIDTH_DEFAULT  = 16;
   localparam int unsigned GRID_HEIGHT_DEFAULT = 8;
   localparam int unsigned MAX_ROWS_OUT        = 8;

   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned PERIOD_WIDTH    = 16;
   localparam int unsigned SEED_WIDTH      = 16;
   localparam int unsigned ROW_BITS_WIDTH  = 16;
   localparam int unsigned ROW_INDEX_WIDTH = 3;
   localparam int unsigned COLOR_WIDTH     = 3;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd150;

   // xorshift16 shift amounts: left, right, left
   localparam int unsigned XS_SHIFT_A = 7;
   localparam int unsigned XS_SHIFT_B = 9;
   localparam int unsigned XS_SHIFT_C = 8;

   localparam int unsigned COLOR_MOD = 7;

   typedef struct packed {
      logic                  key_pressed;
      logic [TIME_WIDTH-1:0] now;
   } req_type;

   typedef struct packed {
      logic [ROW_INDEX_WIDTH-1:0] row_index;
      logic [ROW_BITS_WIDTH-1:0]  row_bits;
      logic [COLOR_WIDTH-1:0]     color_index;
      logic                       last_row;
   } rsp_type;

   // broadcast to every row cell
   typedef struct packed {
      logic load;   // take the xorshift reseed value
      logic step;   // advance one generation
   } cell_ctl_type;

   // apply the xorshift step a number of times
   function automatic logic [SEED_WIDTH-1:0] xs_power(logic [SEED_WIDTH-1:0] v,
                                                      int unsigned steps);
      logic [SEED_WIDTH-1:0] s;
      s = v;
      for (int unsigned i = 0; i < steps; i++) begin
         s = s ^ (s << XS_SHIFT_A);
         s = s ^ (s >> XS_SHIFT_B);
         s = s ^ (s << XS_SHIFT_C);
      end
      return s;
   endfunction

   // xorshift is linear over GF(2): bit bit_pos of xs^steps(seed) is the
   // parity of seed AND this mask
   function automatic logic [SEED_WIDTH-1:0] xs_mask(int unsigned steps,
                                                     int unsigned bit_pos);
      logic [SEED_WIDTH-1:0] m;
      logic [SEED_WIDTH-1:0] col;
      m = '0;
      for (int unsigned j = 0; j < SEED_WIDTH; j++) begin
         col  = xs_power(SEED_WIDTH'(1) << j, steps);
         m[j] = col[bit_pos];
      end
      return m;
   endfunction

   // (gen / 8) mod 7; since 8 = 1 mod 7 the octal digits of gen / 8 are summed
   function automatic logic [COLOR_WIDTH-1:0] color_of(logic [TIME_WIDTH-1:0] gen);
      logic [29:0] q;
      logic [6:0]  digit_sum;
      logic [3:0]  fold1;
      logic [3:0]  fold2;
      q         = {1'b0, gen[TIME_WIDTH-1:3]};
      digit_sum = '0;
      for (int unsigned i = 0; i < 10; i++) begin
         digit_sum = digit_sum + 7'(q[3*i +: 3]);
      end
      fold1 = 4'(digit_sum[6:3]) + 4'(digit_sum[2:0]);
      fold2 = 4'(fold1[3]) + 4'(fold1[2:0]);
      if (fold2 >= 4'(COLOR_MOD)) begin
         fold2 = fold2 - 4'(COLOR_MOD);
      end
      return fold2[COLOR_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/core/tle_row_cell.sv =====
// ----------------------------------------------------------------------------
// Row cell
// Holds one grid row; steps it from its wrap-around neighbours or reloads it
// with its own xorshift output.
// ----------------------------------------------------------------------------
module tle_row_cell #(
   parameter int unsigned ROW   = 0,
   parameter int unsigned WIDTH = tle_pkg::GRID_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tle_pkg::cell_ctl_type           ctl,
   input  logic [tle_pkg::SEED_WIDTH-1:0]  seed,
   input  logic [WIDTH-1:0]                up_row,
   input  logic [WIDTH-1:0]                dn_row,
   output logic [WIDTH-1:0]                row
);
   import tle_pkg::*;

   logic [WIDTH-1:0]      row_ff;
   logic [WIDTH-1:0]      row_in;
   logic [WIDTH-1:0]      life_row;
   logic [WIDTH-1:0]      seed_row;
   logic [SEED_WIDTH-1:0] xs_row;

   // row ROW takes the (ROW+1)th xorshift output
   for (genvar k = 0; k < SEED_WIDTH; k++) begin : g_xs
      localparam logic [SEED_WIDTH-1:0] MASK = xs_mask(ROW + 1, k);
      assign xs_row[k] = ^(seed & MASK);
   end

   for (genvar c = 0; c < WIDTH; c++) begin : g_seed
      if (c < SEED_WIDTH) begin : g_bit
         assign seed_row[c] = xs_row[c];
      end else begin : g_zero
         assign seed_row[c] = 1'b0;
      end
   end

   // B3/S23 per column
   always_comb begin
      logic [3:0]  n;
      int unsigned lf;
      int unsigned rt;
      for (int unsigned c = 0; c < WIDTH; c++) begin
         lf = (c == 0) ? WIDTH - 1 : c - 1;
         rt = (c == WIDTH - 1) ? 0 : c + 1;
         n  = 4'(up_row[lf]) + 4'(up_row[c]) + 4'(up_row[rt])
            + 4'(row_ff[lf]) + 4'(row_ff[rt])
            + 4'(dn_row[lf]) + 4'(dn_row[c]) + 4'(dn_row[rt]);
         life_row[c] = (n == 4'd3) || (row_ff[c] && (n == 4'd2));
      end
   end

   always_comb begin
      row_in = row_ff;
      if (ctl.load) begin
         row_in = seed_row;
      end else if (ctl.step) begin
         row_in = life_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row = row_ff;

endmodule

// ===== rtl/core/tle_rsp_chain.sv =====
// ----------------------------------------------------------------------------
// Response chain
// Snapshot of the reported rows; shifts one row towards the port per response.
// ----------------------------------------------------------------------------
`include "toroidal_life_engine_assert.svh"

module tle_rsp_chain #(
   parameter int unsigned ROWS = tle_pkg::MAX_ROWS_OUT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [tle_pkg::ROW_BITS_WIDTH-1:0]  load_rows [ROWS],
   input  logic [tle_pkg::COLOR_WIDTH-1:0]     load_color,
   output logic                                free,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tle_pkg::rsp_type                    rsp_payload
);
   import tle_pkg::*;

   localparam int unsigned COUNT_W = $clog2(ROWS + 1);

   logic [ROW_BITS_WIDTH-1:0]  rows_ff [ROWS];
   logic [COLOR_WIDTH-1:0]     color_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic [ROW_INDEX_WIDTH-1:0] idx_ff;
   logic                       take;

   assign rsp_valid = (count_ff != '0);
   assign take      = rsp_valid && !rsp_stall;
   // empty now, or last row leaves this edge
   assign free      = (count_ff == '0) || ((count_ff == COUNT_W'(1)) && !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         count_ff <= COUNT_W'(ROWS);
         idx_ff   <= '0;
      end else if (take) begin
         count_ff <= count_ff - 1'b1;
         idx_ff   <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rows_ff  <= load_rows;
         color_ff <= load_color;
      end else if (take) begin
         for (int unsigned i = 0; i < ROWS - 1; i++) begin
            rows_ff[i] <= rows_ff[i+1];
         end
      end
   end

   assign rsp_payload.row_index   = idx_ff;
   assign rsp_payload.row_bits    = rows_ff[0];
   assign rsp_payload.color_index = color_ff;
   assign rsp_payload.last_row    = (count_ff == COUNT_W'(1));

   `TLE_ASSERT_IMP(a_last_row_index, clock, reset, rsp_valid && rsp_payload.last_row, idx_ff == ROW_INDEX_WIDTH'(ROWS - 1))
   `TLE_ASSERT_NXT(a_load_full, clock, reset, load, count_ff == COUNT_W'(ROWS) && idx_ff == '0)

endmodule

// ===== rtl/core/toroidal_life_engine.sv =====
// ----------------------------------------------------------------------------
// Toroidal life engine - B3/S23 on a wrap-around grid, one row cell per row
// The response chain gives out one row per cycle while rsp_stall is low and
//   so sets the request rate; a new request may enter as the previous one
//   hands its rows over, and a reseed adds no state to the sequence.
// Reset (synchronous): grid, generation count and last step time cleared,
//   period_ms back to 150. No clearing pass, requests taken at once.
// ----------------------------------------------------------------------------
`include "toroidal_life_engine_assert.svh"

module toroidal_life_engine #(
   parameter int unsigned GRID_WIDTH  = tle_pkg::GRID_WIDTH_DEFAULT,
   parameter int unsigned GRID_HEIGHT = tle_pkg::GRID_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tle_pkg::req_type                  req_payload,
   // response channel, one row per response
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tle_pkg::rsp_type                  rsp_payload,
   // period register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tle_pkg::PERIOD_WIDTH-1:0]  csr_period_ms
);
   import tle_pkg::*;

   localparam int unsigned ROWS_OUT =
      (GRID_HEIGHT < MAX_ROWS_OUT) ? GRID_HEIGHT : MAX_ROWS_OUT;

   // Request sequence:
   //   CHECK - key reseed, decide on a generation against period_ms
   //   STEP  - every cell takes its next generation
   //   EMPTY - reseed if nothing survived
   //   HAND  - copy the rows into the response chain once it has room
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_EMPTY,
      ST_HAND
   } state_type;

   state_type               state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [TIME_WIDTH-1:0]   gen_ff, gen_in;
   logic [TIME_WIDTH-1:0]   last_ff, last_in;
   logic [PERIOD_WIDTH-1:0] period_ff, period_in;

   logic                    req_take;
   logic                    out_free;
   logic                    out_load;
   logic [TIME_WIDTH-1:0]   elapsed;
   logic                    period_hit;
   logic                    grid_empty;
   logic [SEED_WIDTH-1:0]   seed;
   cell_ctl_type            cell_ctl;

   logic [GRID_WIDTH-1:0]     cell_row  [GRID_HEIGHT];
   logic [ROW_BITS_WIDTH-1:0] snap_rows [ROWS_OUT];

   // --- grid: ring of row cells, each sees the rows above and below ---
   for (genvar r = 0; r < GRID_HEIGHT; r++) begin : g_cell
      tle_row_cell #(
         .ROW   (r),
         .WIDTH (GRID_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (cell_ctl),
         .seed   (seed),
         .up_row (cell_row[(r + GRID_HEIGHT - 1) % GRID_HEIGHT]),
         .dn_row (cell_row[(r + 1) % GRID_HEIGHT]),
         .row    (cell_row[r])
      );
   end

   // seed is (now mod 65536) | 1 in both reseed cases
   assign seed = item_ff.now[SEED_WIDTH-1:0] | SEED_WIDTH'(1);

   always_comb begin
      grid_empty = 1'b1;
      for (int unsigned r = 0; r < GRID_HEIGHT; r++) begin
         if (cell_row[r] != '0) begin
            grid_empty = 1'b0;
         end
      end
   end

   // a key reseed sets last to now, so only a zero period fires then
   assign elapsed    = item_ff.now - last_ff;
   assign period_hit = item_ff.key_pressed ? (period_ff == '0)
                                           : (elapsed >= TIME_WIDTH'(period_ff));

   // --- response chain ---
   for (genvar r = 0; r < ROWS_OUT; r++) begin : g_snap
      assign snap_rows[r] = ROW_BITS_WIDTH'(cell_row[r]);
   end

   tle_rsp_chain #(
      .ROWS (ROWS_OUT)
   ) u_rsp_chain (
      .clock       (clock),
      .reset       (reset),
      .load        (out_load),
      .load_rows   (snap_rows),
      .load_color  (color_of(gen_ff)),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // next request may enter as the previous one hands its rows over
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_HAND) && out_free));
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // --- sequencer ---
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      gen_in    = gen_ff;
      last_in   = last_ff;
      period_in = csr_valid ? csr_period_ms : period_ff;
      cell_ctl  = '0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in  = req_payload;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (item_ff.key_pressed) begin
               cell_ctl.load = 1'b1;
               gen_in        = '0;
               last_in       = item_ff.now;
            end
            state_in = period_hit ? ST_STEP : ST_HAND;
         end
         ST_STEP: begin
            cell_ctl.step = 1'b1;
            last_in       = item_ff.now;
            gen_in        = gen_ff + 1'b1;
            state_in      = ST_EMPTY;
         end
         ST_EMPTY: begin
            // dead grid: fresh pattern, count restarts
            if (grid_empty) begin
               cell_ctl.load = 1'b1;
               gen_in        = '0;
            end
            state_in = ST_HAND;
         end
         ST_HAND: begin
            if (out_free) begin
               out_load = 1'b1;
               if (req_take) begin
                  item_in  = req_payload;
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         gen_ff    <= '0;
         last_ff   <= '0;
         period_ff <= PERIOD_RESET;
      end else begin
         state_ff  <= state_in;
         gen_ff    <= gen_in;
         last_ff   <= last_in;
         period_ff <= period_in;
      end
      item_ff <= item_in;
   end

   `TLE_ASSERT_NXT(a_take_starts_check, clock, reset, req_take, state_ff == ST_CHECK)
   `TLE_ASSERT_NXT(a_step_counts, clock, reset, state_ff == ST_STEP, gen_ff == $past(gen_ff) + 1'b1)
   `TLE_ASSERT_IMP(a_empty_after_step, clock, reset, state_ff == ST_EMPTY, $past(state_ff) == ST_STEP)

endmodule

// ===== tb/life_row_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life engine row checker
// Watches the request, response and period channels. It keeps its own copy of
// the grid, generation count and step time, and works out the eight row
// responses of every accepted request. Each response is matched in order.
// ----------------------------------------------------------------------------
module life_row_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  tle_pkg::req_type                 req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  tle_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [tle_pkg::PERIOD_WIDTH-1:0] csr_period_ms,
   output int                               mismatches,
   output int                               rows_owed
);
   import tle_pkg::*;

   localparam int ROWS     = GRID_HEIGHT_DEFAULT;
   localparam int COLS     = GRID_WIDTH_DEFAULT;
   localparam int ROWS_OUT = (ROWS < MAX_ROWS_OUT) ? ROWS : MAX_ROWS_OUT;

   logic [COLS-1:0]         grid [ROWS];
   logic [TIME_WIDTH-1:0]   gen_count  = '0;
   logic [TIME_WIDTH-1:0]   last_step  = '0;
   logic [PERIOD_WIDTH-1:0] period     = PERIOD_RESET;
   rsp_type                 rows_due [$];

   initial begin
      mismatches = 0;
      rows_owed  = 0;
      foreach (grid[r]) grid[r] = '0;
   end

   function automatic logic [SEED_WIDTH-1:0] xorshift16(logic [SEED_WIDTH-1:0] v);
      v = v ^ (v << 7);
      v = v ^ (v >> 9);
      v = v ^ (v << 8);
      return v;
   endfunction

   function automatic void seed_grid(logic [TIME_WIDTH-1:0] t);
      logic [SEED_WIDTH-1:0] s;
      s = t[SEED_WIDTH-1:0] | SEED_WIDTH'(1);
      for (int r = 0; r < ROWS; r++) begin
         s       = xorshift16(s);
         grid[r] = COLS'(s);
      end
      gen_count = '0;
      last_step = t;
   endfunction

   // B3/S23 on the torus
   function automatic void step_generation();
      logic [COLS-1:0] nxt [ROWS];
      int n;
      for (int r = 0; r < ROWS; r++) begin
         nxt[r] = '0;
         for (int c = 0; c < COLS; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     n += int'(grid[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS]);
                  end
               end
            end
            if (n == 3 || (grid[r][c] && n == 2)) begin
               nxt[r][c] = 1'b1;
            end
         end
      end
      foreach (grid[r]) grid[r] = nxt[r];
      gen_count = gen_count + 1'b1;
   endfunction

   function automatic logic grid_dead();
      foreach (grid[r]) begin
         if (grid[r] != '0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_rows(req_type req);
      rsp_type row;
      if (req.key_pressed) begin
         seed_grid(req.now);
      end
      if (req.now - last_step >= TIME_WIDTH'(period)) begin
         last_step = req.now;
         step_generation();
         if (grid_dead()) begin
            seed_grid(req.now);
         end
      end
      for (int r = 0; r < ROWS_OUT; r++) begin
         row.row_index   = ROW_INDEX_WIDTH'(r);
         row.row_bits    = grid[r][ROW_BITS_WIDTH-1:0];
         row.color_index = COLOR_WIDTH'((gen_count >> 3) % COLOR_MOD);
         row.last_row    = (r == ROWS_OUT - 1);
         rows_due.push_back(row);
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         foreach (grid[r]) grid[r] = '0;
         gen_count = '0;
         last_step = '0;
         period    = PERIOD_RESET;
         rows_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            period = csr_period_ms;
         end
         if (rsp_valid && !rsp_stall) begin
            if (rows_due.size() == 0) begin
               $display("%0t: row response with none expected, expected none got %p",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               want = rows_due.pop_front();
               check_field("row_index", want.row_index, rsp_payload.row_index);
               check_field("row_bits", want.row_bits, rsp_payload.row_bits);
               check_field("color_index", want.color_index, rsp_payload.color_index);
               check_field("last_row", want.last_row, rsp_payload.last_row);
            end
         end
         if (req_valid && !req_stall) begin
            predict_rows(req_payload);
         end
      end
      rows_owed <= rows_due.size();
   end

endmodule

// ===== tb/tb_toroidal_life_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Toroidal life engine testbench
// Drives update requests and period writes into the engine, with random
// idling on both channels. The row checker beside the engine predicts and
// compares every row; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_toroidal_life_engine;
   import tle_pkg::*;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   req_type                 req_payload   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   rsp_type                 rsp_payload;
   logic                    csr_valid     = 1'b0;
   logic                    csr_ready;
   logic [PERIOD_WIDTH-1:0] csr_period_ms = '0;

   int mismatches;
   int rows_owed;

   // random idling on both sides; dropped for one whole phase
   logic                    throttle_on = 1'b1;
   // last time stamp sent and the period the engine now holds
   logic [TIME_WIDTH-1:0]   tick        = '0;
   logic [PERIOD_WIDTH-1:0] period_now  = PERIOD_RESET;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   toroidal_life_engine u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_period_ms (csr_period_ms)
   );

   life_row_checker u_rows (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_period_ms (csr_period_ms),
      .mismatches    (mismatches),
      .rows_owed     (rows_owed)
   );

   // response side back-pressure, stalled at random about 36 percent of the time
   always @(posedge clock) begin
      rsp_stall <= throttle_on && ($urandom_range(99) < 36);
   end

   // One update request. Idle cycles go in front of it at random, then it is
   // held until the engine takes it. req_valid stays high on return so that a
   // back-to-back request needs no second assignment in the same step.
   task automatic send_update(input logic key, input logic [TIME_WIDTH-1:0] t);
      while (throttle_on && ($urandom_range(99) < 36)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{key_pressed: key, now: t};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick = t;
   endtask

   // Drop the request line and wait for every owed row, plus a margin for the
   // engine's pipeline.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_WIDTH-1:0] p);
      csr_valid     <= 1'b1;
      csr_period_ms <= p;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      period_now = p;
   endtask

   // Random traffic, mostly well-formed: the clock moves on by about one
   // period so that generations keep running and the colour index climbs.
   task automatic random_update();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) begin
         send_update(1'b0, tick + period_now + $urandom_range(0, 3));
      end else if (pick < 82) begin
         // too early for a generation
         send_update(1'b0, tick + $urandom_range(0, period_now - 1));
      end else if (pick < 88) begin
         send_update(1'b1, tick + $urandom_range(0, 3));
      end else if (pick < 95) begin
         // noise: any time stamp, any key state
         send_update(1'($urandom_range(1)), $urandom());
      end else begin
         // close to the 32-bit wrap of the tick counter
         send_update(1'b0, 32'hFFFF_FF00 + $urandom_range(0, 255));
      end
   endtask

   initial begin : stimulus
      logic [PERIOD_WIDTH-1:0] phase_period [6];
      int                      phase_len    [6];

      phase_period = '{16'd1, PERIOD_RESET, 16'hFFFF, 16'd0, 16'd2, 16'd1};
      phase_len    = '{70, 40, 30, 40, 40, 30};
      phase_period[3] = PERIOD_WIDTH'($urandom_range(1, 65535));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, period at its reset value of 150 ---
      send_update(1'b0, 32'd0);             // empty grid, nothing due
      send_update(1'b0, 32'd149);           // one tick short
      send_update(1'b0, 32'd150);           // generation on a dead grid reseeds
      send_update(1'b1, 32'd0);             // key reseed from seed 1
      send_update(1'b1, 32'hFFFF_FFFF);     // seed all ones
      send_update(1'b0, 32'h0000_0095);     // elapsed 150 across the wrap
      send_update(1'b1, 32'h0001_0000);     // upper half ignored by the seed
      send_update(1'b0, 32'h0000_0000);     // time went backwards: huge elapsed
      send_update(1'b1, 32'hAAAA_5555);
      send_update(1'b1, 32'h5555_AAAA);
      send_update(1'b0, 32'h5555_AAAA + 32'd149);

      // shortest period: a generation on every request
      drain();
      write_period(16'd1);
      for (int i = 0; i < 10; i++) begin
         send_update(1'b0, tick + 1'b1);
      end

      // longest period, just short and then past it
      drain();
      write_period(16'hFFFF);
      send_update(1'b0, tick + 32'd65534);
      send_update(1'b0, tick + 32'd65535);

      // --- random part, one period per phase; phase 2 runs without idling ---
      for (int p = 0; p < 6; p++) begin
         drain();
         write_period(phase_period[p]);
         throttle_on = (p != 2);
         for (int i = 0; i < phase_len[p]; i++) begin
            random_update();
         end
      end
      throttle_on = 1'b1;

      drain();
      if (mismatches == 0 && rows_owed == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
